>>> hw/rtl/asn1_ber_tlv_stream_parser_assert.svh
// Assertion macros shared by the checker of the TLV stream parser.
// Expects signals clk and arst_n in the scope of use.
`ifndef ASN1_BER_TLV_STREAM_PARSER_ASSERT_SVH
`define ASN1_BER_TLV_STREAM_PARSER_ASSERT_SVH

// same-cycle implication
`define ABTSP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ABTSP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> hw/rtl/abtsp_pkg.sv
// Types and constants of the TLV stream parser.
// No dependencies.
`default_nettype none
package abtsp_pkg;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        first_byte;
		logic [31:0] message_length;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  error_code;
		logic [63:0] tag_value;
		logic [3:0]  tag_byte_count;
		logic        constructed;
		logic        indefinite;
		logic [31:0] content_length;
		logic [31:0] start_offset;
		logic [5:0]  nesting_level;
		logic        message_done;
	} result_t;

	localparam logic [1:0] KIND_HDR  = 2'd0;
	localparam logic [1:0] KIND_EOC  = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;
	localparam logic [1:0] KIND_DONE = 2'd3;

	localparam logic [2:0] ERR_TRUNC    = 3'd0;
	localparam logic [2:0] ERR_LEN_FORM = 3'd1;
	localparam logic [2:0] ERR_OVERRUN  = 3'd2;
	localparam logic [2:0] ERR_DEEP     = 3'd3;
	localparam logic [2:0] ERR_TAG_LONG = 3'd4;

	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_TAG   = 3'd1;
	localparam logic [2:0] PH_TAGX  = 3'd2;
	localparam logic [2:0] PH_LEN   = 3'd3;
	localparam logic [2:0] PH_LENX  = 3'd4;
	localparam logic [2:0] PH_SKIP  = 3'd5;
	localparam logic [2:0] PH_DRAIN = 3'd6;

	localparam logic [31:0] LEN_MAX   = 32'hFFFF_FFFF;
	localparam logic [31:0] LEN_SHMAX = 32'h00FF_FFFF;
	localparam logic [4:0]  TAG_EXT   = 5'h1f;
	localparam logic [7:0]  LEN_INDEF = 8'h80;
	localparam logic [6:0]  LEN_BYTES_MAX = 7'd8;

endpackage
`default_nettype wire

>>> hw/rtl/abtsp_stream_if.sv
// Valid/ready stream channel with a typed payload.
// No dependencies.
`default_nettype none
interface abtsp_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/abtsp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module abtsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

>>> hw/rtl/abtsp_front.sv
// Front end: accepts bytes, walks the TLV headers, keeps the end-offset stack.
// Depends on abtsp_pkg and abtsp_ram.
`default_nettype none
module abtsp_front import abtsp_pkg::*; #(
	parameter int MAX_DEPTH     = 32,
	parameter int OFFSET_WIDTH  = 32,
	parameter int MAX_TAG_BYTES = 8
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire in_item_t in_item,
	output logic          in_ready,
	input  wire logic     q_space,
	output logic          rec_push,
	output result_t       rec
);
	localparam int DW = $clog2(MAX_DEPTH + 1);
	localparam int OW = OFFSET_WIDTH;
	localparam int LW = ((OW > 32) ? OW : 32) + 1;
	localparam int EW = OW + DW;
	localparam logic [DW-1:0] DEPTH_LIM = DW'(MAX_DEPTH);
	localparam logic [3:0]    TAG_LIM   = 4'(MAX_TAG_BYTES);

	logic [2:0]    phase_q;
	logic          halted_q;
	logic [OW-1:0] off_q, estart_q, top_end_q, msg_end_q, skip_q;
	logic [63:0]   tag_q;
	logic [3:0]    tcnt_q, lleft_q;
	logic          cons_q;
	logic [31:0]   lacc_q;
	logic [DW-1:0] depth_q, top_tgt_q;

	logic [2:0]    phase_n;
	logic          halted_n;
	logic [OW-1:0] off_n, estart_n, top_end_n, msg_end_n, skip_n;
	logic [63:0]   tag_n;
	logic [3:0]    tcnt_n, lleft_n;
	logic          cons_n;
	logic [31:0]   lacc_n;
	logic [DW-1:0] depth_n, top_tgt_n;

	logic          acc, work;
	logic [7:0]    b;
	logic [LW-1:0] mlen_w, nxt, encl, rem, c_len, off_cnt;
	logic [OW-1:0] mend;
	logic [2:0]    ph;
	logic          done;
	logic          hd_go, hd_indef;
	logic [31:0]   hd_len;
	logic          em_go;
	logic [1:0]    em_kind;
	logic [2:0]    em_code;
	logic [31:0]   em_len;
	logic          em_indef;
	logic          we;
	logic [DW-1:0] waddr, new_tgt, raddr;
	logic [EW-1:0] wdata, rdata;
	logic [3:0]    tcnt_inc;
	logic [3:0]    lleft_dec;
	logic [31:0]   lacc_sh;

	assign in_ready = q_space;
	assign acc      = in_valid & in_ready;
	assign b        = in_item.data_byte;
	assign mlen_w   = LW'(in_item.message_length);
	assign mend     = in_item.first_byte ? mlen_w[OW-1:0] : msg_end_q;
	// keep reading the live pop target while no byte is taken
	assign raddr    = acc ? top_tgt_n : top_tgt_q;

	// stack entries: {end offset, depth that a pop of this entry falls back to}
	abtsp_ram #(.WIDTH(EW), .DEPTH(MAX_DEPTH + 1)) u_stack (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	always_comb begin
		// start of message folds into this byte's step
		ph        = in_item.first_byte ? PH_TAG : phase_q;
		halted_n  = in_item.first_byte ? 1'b0 : halted_q;
		off_n     = in_item.first_byte ? '0 : off_q;
		depth_n   = in_item.first_byte ? '0 : depth_q;
		top_end_n = in_item.first_byte ? mlen_w[OW-1:0] : top_end_q;
		top_tgt_n = in_item.first_byte ? '0 : top_tgt_q;
		tag_n     = in_item.first_byte ? '0 : tag_q;
		tcnt_n    = in_item.first_byte ? '0 : tcnt_q;
		cons_n    = in_item.first_byte ? 1'b0 : cons_q;
		lacc_n    = in_item.first_byte ? '0 : lacc_q;
		lleft_n   = in_item.first_byte ? '0 : lleft_q;
		estart_n  = in_item.first_byte ? '0 : estart_q;
		skip_n    = in_item.first_byte ? '0 : skip_q;
		msg_end_n = mend;
		phase_n   = ph;

		nxt      = LW'(off_n) + LW'(1);
		encl     = LW'(top_end_n);
		done     = (nxt == LW'(mend));
		work     = acc && !halted_n && (ph != PH_IDLE) && (LW'(off_n) < LW'(mend));
		rem      = (encl > nxt) ? (encl - nxt) : '0;
		off_cnt  = LW'(off_n) + LW'(b[6:0]);
		tcnt_inc = tcnt_n + 4'd1;
		lleft_dec = lleft_n - 4'd1;
		lacc_sh  = (lacc_n > LEN_SHMAX) ? LEN_MAX : {lacc_n[23:0], b};

		hd_go = 1'b0; hd_len = '0; hd_indef = 1'b0;
		em_go = 1'b0; em_kind = KIND_HDR; em_code = ERR_TRUNC;
		em_len = '0; em_indef = 1'b0;
		we = 1'b0; waddr = '0; wdata = '0; new_tgt = '0; c_len = '0;

		if (acc && in_item.first_byte) begin
			// entry 0 holds the message end
			we = 1'b1;
			wdata = {mend, {DW{1'b0}}};
		end

		if (work) begin
			case (ph)
				PH_TAG: begin
					estart_n = off_n;
					tag_n    = 64'(b);
					tcnt_n   = 4'd1;
					cons_n   = b[5];
					phase_n  = (b[4:0] == TAG_EXT) ? PH_TAGX : PH_LEN;
					if (nxt >= encl) begin
						em_go = 1'b1; em_kind = KIND_ERR; em_code = ERR_TRUNC;
					end
				end
				PH_TAGX: begin
					if (tcnt_inc > TAG_LIM) begin
						em_go = 1'b1; em_kind = KIND_ERR; em_code = ERR_TAG_LONG;
					end else begin
						tcnt_n = tcnt_inc;
						tag_n  = {tag_n[55:0], b};
						if (!b[7]) begin
							phase_n = PH_LEN;
						end
						if (nxt >= encl) begin
							em_go = 1'b1; em_kind = KIND_ERR; em_code = ERR_TRUNC;
						end
					end
				end
				PH_LEN: begin
					if (b == LEN_INDEF) begin
						hd_go    = 1'b1;
						hd_indef = 1'b1;
						hd_len   = (rem > LW'(LEN_MAX)) ? LEN_MAX : rem[31:0];
					end else if (b[7]) begin
						if (b[6:0] > LEN_BYTES_MAX || off_cnt >= encl) begin
							em_go = 1'b1; em_kind = KIND_ERR; em_code = ERR_LEN_FORM;
						end else begin
							lacc_n  = '0;
							lleft_n = b[3:0];
							phase_n = PH_LENX;
						end
					end else begin
						hd_go  = 1'b1;
						hd_len = 32'(b);
					end
				end
				PH_LENX: begin
					lacc_n  = lacc_sh;
					lleft_n = lleft_dec;
					if (lleft_dec == 4'd0) begin
						hd_go  = 1'b1;
						hd_len = lacc_sh;
					end
				end
				PH_SKIP: begin
					if (nxt >= LW'(skip_n)) begin
						phase_n = PH_TAG;
					end
				end
				default: begin
				end
			endcase

			if (hd_go) begin
				c_len = nxt + LW'(hd_len);
				if (tcnt_n == 4'd1 && tag_n == 64'd0 && hd_len == 32'd0) begin
					em_go = 1'b1; em_kind = KIND_EOC; em_indef = hd_indef;
					if (depth_n == '0) begin
						phase_n = PH_DRAIN;
					end else if (nxt < encl) begin
						skip_n  = top_end_n;
						phase_n = PH_SKIP;
					end else begin
						phase_n = PH_TAG;
					end
				end else if (nxt > encl || LW'(hd_len) > (encl - nxt)) begin
					em_go = 1'b1; em_kind = KIND_ERR; em_code = ERR_OVERRUN;
				end else if (cons_n) begin
					if (depth_n == DEPTH_LIM) begin
						em_go = 1'b1; em_kind = KIND_ERR; em_code = ERR_DEEP;
					end else begin
						em_go = 1'b1; em_len = hd_len; em_indef = hd_indef;
						phase_n = PH_TAG;
						// an empty constructed element pops at once: no push
						if (hd_len != 32'd0) begin
							new_tgt = (c_len == encl && depth_n != '0) ? top_tgt_n : depth_n;
							we        = 1'b1;
							waddr     = depth_n + DW'(1);
							wdata     = {c_len[OW-1:0], new_tgt};
							depth_n   = depth_n + DW'(1);
							top_end_n = c_len[OW-1:0];
							top_tgt_n = new_tgt;
						end
					end
				end else begin
					em_go = 1'b1; em_len = hd_len; em_indef = hd_indef;
					if (hd_len == 32'd0) begin
						phase_n = PH_TAG;
					end else begin
						skip_n  = c_len[OW-1:0];
						phase_n = PH_SKIP;
					end
				end
			end

			off_n = nxt[OW-1:0];
			if ((em_go && em_kind == KIND_ERR) || done) begin
				halted_n = 1'b1;
			end
			// pop all levels ending here; the entry records how far to fall
			if (phase_n == PH_TAG && depth_n != '0 && nxt == LW'(top_end_n)) begin
				depth_n   = top_tgt_n;
				top_end_n = (top_tgt_n == '0) ? mend : rdata[EW-1:DW];
				top_tgt_n = rdata[DW-1:0];
			end
		end else if (acc && ph != PH_IDLE && !halted_n) begin
			halted_n = 1'b1; // byte beyond message end
		end
	end

	always_comb begin
		rec_push = work && (em_go || done);
		rec = '0;
		if (em_go) begin
			rec.kind           = em_kind;
			rec.error_code     = em_code;
			rec.tag_value      = tag_n;
			rec.tag_byte_count = tcnt_n;
			rec.constructed    = cons_n;
			rec.indefinite     = em_indef;
			rec.content_length = em_len;
			rec.start_offset   = 32'(estart_n);
			rec.nesting_level  = 6'(in_item.first_byte ? '0 : depth_q);
		end else begin
			rec.kind = KIND_DONE;
		end
		rec.message_done = done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			halted_q  <= 1'b0;
			off_q     <= '0;
			depth_q   <= '0;
			top_end_q <= '0;
			top_tgt_q <= '0;
			msg_end_q <= '0;
			tag_q     <= '0;
			tcnt_q    <= '0;
			cons_q    <= 1'b0;
			lacc_q    <= '0;
			lleft_q   <= '0;
			estart_q  <= '0;
			skip_q    <= '0;
		end else if (acc) begin
			phase_q   <= phase_n;
			halted_q  <= halted_n;
			off_q     <= off_n;
			depth_q   <= depth_n;
			top_end_q <= top_end_n;
			top_tgt_q <= top_tgt_n;
			msg_end_q <= msg_end_n;
			tag_q     <= tag_n;
			tcnt_q    <= tcnt_n;
			cons_q    <= cons_n;
			lacc_q    <= lacc_n;
			lleft_q   <= lleft_n;
			estart_q  <= estart_n;
			skip_q    <= skip_n;
		end
	end
endmodule
`default_nettype wire

>>> hw/rtl/abtsp_back.sv
// Back end: two-entry result queue that drives the result channel.
// Depends on abtsp_pkg.
`default_nettype none
module abtsp_back import abtsp_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    rec_push,
	input  wire result_t rec,
	output logic         q_space,
	output logic         out_valid,
	input  wire logic    out_ready,
	output result_t      out_data
);
	result_t    slot_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = slot_q[rd_q];
	assign pop       = out_valid & out_ready;
	assign q_space   = (cnt_q != 2'd2) | out_ready;

	always_ff @(posedge clk) begin
		if (rec_push) begin
			slot_q[wr_q] <= rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (rec_push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, rec_push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

>>> hw/rtl/asn1_ber_tlv_stream_parser.sv
// BER/DER TLV stream parser, top level.
// Depends on abtsp_pkg, abtsp_stream_if, abtsp_front, abtsp_back, abtsp_ram.
//
// Usage:
//  bytes   : one message byte per request (data_byte, first_byte, message_length).
//            first_byte restarts parsing at offset 0 for a message of
//            message_length bytes.
//  results : zero or one request per byte: element header, end-of-contents,
//            error or message done.
//  Throughput: one byte per cycle while the result queue has space. Each
//  byte touches only the stack top; a pop to any outer level needs no walk
//  down the stack because each stack entry records the depth it falls back
//  to, and the RAM prefetches that entry continuously.
//  A result is registered in the result queue when its byte is taken.
//  A two-entry result queue sits between the parser and the result channel;
//  while results stalls, bytes are still taken until the queue is full,
//  then bytes.ready drops. No result is lost.
//  Reset: asynchronous; the parser ignores bytes until a first_byte, and
//  the queue empties. The stack RAM needs no clearing.
`default_nettype none
module asn1_ber_tlv_stream_parser import abtsp_pkg::*; #(
	parameter int MAX_DEPTH     = 32,
	parameter int OFFSET_WIDTH  = 32,
	parameter int MAX_TAG_BYTES = 8
) (
	input wire logic         clk,
	input wire logic         arst_n,
	abtsp_stream_if.sink     bytes,
	abtsp_stream_if.source   results
);
	logic    q_space;
	logic    rec_push;
	result_t rec;
	result_t out_data;

	// front: header walk and depth stack
	abtsp_front #(
		.MAX_DEPTH(MAX_DEPTH),
		.OFFSET_WIDTH(OFFSET_WIDTH),
		.MAX_TAG_BYTES(MAX_TAG_BYTES)
	) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(bytes.valid), .in_item(bytes.data), .in_ready(bytes.ready),
		.q_space(q_space), .rec_push(rec_push), .rec(rec)
	);

	// back: result queue and output handshake
	abtsp_back u_back (
		.clk(clk), .arst_n(arst_n),
		.rec_push(rec_push), .rec(rec), .q_space(q_space),
		.out_valid(results.valid), .out_ready(results.ready), .out_data(out_data)
	);

	assign results.data = out_data;
endmodule
`default_nettype wire

>>> hw/rtl/abtsp_chk.sv
// Port-level checker for the TLV stream parser, bound to the top level.
// Depends on abtsp_pkg and asn1_ber_tlv_stream_parser_assert.svh.
`default_nettype none
`include "asn1_ber_tlv_stream_parser_assert.svh"
module abtsp_chk import abtsp_pkg::*; (
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    out_valid,
	input wire logic    out_ready,
	input wire result_t rsp
);
	`ABTSP_ASSERT_IMP(a_done_flag, out_valid && rsp.kind == KIND_DONE, rsp.message_done)
	`ABTSP_ASSERT_IMP(a_code_zero, out_valid && rsp.kind != KIND_ERR, rsp.error_code == ERR_TRUNC)
	`ABTSP_ASSERT_IMP(a_done_empty, out_valid && rsp.kind == KIND_DONE, rsp.tag_byte_count == 4'd0 && rsp.content_length == 32'd0)
	`ABTSP_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid && $stable(rsp))
endmodule

bind asn1_ber_tlv_stream_parser abtsp_chk u_chk (
	.clk(clk), .arst_n(arst_n),
	.out_valid(results.valid), .out_ready(results.ready), .rsp(results.data)
);
`default_nettype wire
